FILE: rtl/vector3_normalize_core_assert.svh
// Assertion macros for the vector normalization core.
`ifndef VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`define VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define V3N_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define V3N_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define V3N_ASSERT(label, prop)
`define V3N_ASSERT_RST(label, prop)
`endif
`endif

FILE: rtl/v3n_pkg.sv
// Shared types and constants for the vector normalization core.
package v3n_pkg;
  localparam int SqrtStages = 16;
  localparam int DivStages  = 15;

  typedef struct packed {
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;
  } v3n_in_t;

  typedef struct packed {
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic [15:0]        length;
    logic               is_zero;
  } v3n_out_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic [2:0][15:0] mag;
  } v3n_side_t;
endpackage

FILE: rtl/vector3_normalize_core.sv
// Top level of the pipelined 3D vector normalization core.
//
//  channel  signals                       direction
//  in       in_valid, in_stall, in_data   item enters
//  out      out_valid, out_stall, out_data result leaves
//
// One vector per cycle is taken unless the output stalls; its stages are the square, one for
// each of the 16 root bits, the load and one for each of the 15 quotient bits.
// Reset (rst, synchronous) clears every stage's valid bit.
// A stall on the output freezes the whole pipeline only when the last stage
// holds a result; otherwise every stage keeps advancing.
module vector3_normalize_core import v3n_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  v3n_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output v3n_out_t out_data
);
`include "vector3_normalize_core_assert.svh"
  logic      adv, sq_vld;
  logic [15:0] root;
  v3n_side_t side;
  v3n_out_t  dres;
  logic      dvld;

  // Advance everything unless a finished result is held back.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  v3n_sqrt u_sqrt (.clk, .rst, .adv, .in_vld(in_valid && adv), .din(in_data),
                   .out_vld(sq_vld), .root, .side);

  // Quotient has 15 bits with mag <= root; the divider preloads mag >> 1 and
  // brings in the low mag bit and then zeros, one per stage.
  v3n_div u_div (.clk, .rst, .adv, .in_vld(sq_vld), .root, .side,
                 .out_vld(dvld), .dout(dres));

  assign out_valid = dvld;
  assign out_data  = dres;

  `V3N_ASSERT_RST(a_rst_empty, rst |=> !out_valid)
  `V3N_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
  `V3N_ASSERT(a_zero, out_valid && out_data.is_zero |-> out_data.length == 16'd0)
  `V3N_ASSERT(a_stall, in_stall |-> out_valid && out_stall)
endmodule

FILE: rtl/v3n_sqrt.sv
// Pipelined sum of squares and restoring integer square root.
module v3n_sqrt import v3n_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  v3n_in_t       din,
  output logic          out_vld,
  output logic [15:0]   root,
  output v3n_side_t     side
);
  logic [SqrtStages:0]           vld;
  logic [SqrtStages:0][33:0]     rem;
  logic [SqrtStages:0][15:0]     rt;
  logic [SqrtStages:0][31:0]     sum;
  v3n_side_t [SqrtStages:0]      sd;
  logic [2:0][15:0] m;
  logic [2:0] n;
  logic [33:0] s0;

  always_comb begin
    n = {din.comp_x[15], din.comp_y[15], din.comp_z[15]};
    m[2] = din.comp_x[15] ? 16'(-din.comp_x) : din.comp_x;
    m[1] = din.comp_y[15] ? 16'(-din.comp_y) : din.comp_y;
    m[0] = din.comp_z[15] ? 16'(-din.comp_z) : din.comp_z;
    s0 = 34'(32'(m[2]) * 32'(m[2])) + 34'(32'(m[1]) * 32'(m[1]))
       + 34'(32'(m[0]) * 32'(m[0]));
  end

  // Stage 0: squares and sum.
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_vld;
    if (adv) begin
      sum[0] <= s0[31:0];
      rem[0] <= '0;
      rt[0]  <= '0;
      sd[0]  <= '{neg: n, mag: m};
    end
  end

  // One root bit per stage.
  for (genvar i = 0; i < SqrtStages; i++) begin : g_sq
    logic [33:0] r2, trial;
    logic [15:0] rn;
    always_comb begin
      r2 = {rem[i][31:0], sum[i][31:30]};
      trial = r2 - {16'd0, rt[i], 2'b01};
      rn = {rt[i][14:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (adv) vld[i+1] <= vld[i];
      if (adv) begin
        sum[i+1] <= {sum[i][29:0], 2'b00};
        sd[i+1]  <= sd[i];
        if (!trial[33]) begin
          rem[i+1] <= trial;
          rt[i+1]  <= rn | 16'd1;
        end else begin
          rem[i+1] <= r2;
          rt[i+1]  <= rn;
        end
      end
    end
  end

  assign out_vld = vld[SqrtStages];
  assign root    = rt[SqrtStages];
  assign side    = sd[SqrtStages];
endmodule

FILE: rtl/v3n_div.sv
// Pipelined restoring divider for three lanes sharing one divisor.
module v3n_div import v3n_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [15:0] root,
  input  v3n_side_t   side,
  output logic        out_vld,
  output v3n_out_t    dout
);
  logic [DivStages:0]              vld;
  logic [DivStages:0][15:0]        dv;
  logic [DivStages:0][2:0]         ng;
  logic [DivStages:0][2:0][16:0]   rm;
  logic [DivStages:0][2:0][15:0]   nm;
  logic [DivStages:0][2:0][14:0]   qt;

  // Preload mag >> 1 as the partial remainder; the low mag bit waits in nm.
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_vld;
    if (adv) begin
      dv[0] <= root;
      ng[0] <= side.neg;
      for (int k = 0; k < 3; k++) begin
        rm[0][k] <= {2'b00, side.mag[k][15:1]};
        nm[0][k] <= {side.mag[k][0], 15'd0};
        qt[0][k] <= '0;
      end
    end
  end

  // Dividend is mag << 14; bring in one bit per stage, the low mag bit then zeros.
  for (genvar i = 0; i < DivStages; i++) begin : g_dv
    always_ff @(posedge clk) begin
      logic [17:0] sh, t;
      if (rst) vld[i+1] <= 1'b0;
      else if (adv) vld[i+1] <= vld[i];
      if (adv) begin
        dv[i+1] <= dv[i];
        ng[i+1] <= ng[i];
        for (int k = 0; k < 3; k++) begin
          sh = {rm[i][k], nm[i][k][15]};
          t  = sh - {2'b00, dv[i]};
          nm[i+1][k] <= {nm[i][k][14:0], 1'b0};
          if (!t[17]) begin
            rm[i+1][k] <= t[16:0];
            qt[i+1][k] <= {qt[i][k][13:0], 1'b1};
          end else begin
            rm[i+1][k] <= sh[16:0];
            qt[i+1][k] <= {qt[i][k][13:0], 1'b0};
          end
        end
      end
    end
  end

  // Full dividend has 30 bits; the first 15 quotient bits are always zero since
  // mag <= root, so lanes preload the upper mag bits: handled by the first stage.
  logic [2:0][15:0] q;
  logic zero;
  always_comb begin
    zero = (dv[DivStages] == 16'd0);
    for (int k = 0; k < 3; k++)
      q[k] = ng[DivStages][k] ? 16'(-{1'b0, qt[DivStages][k]})
                              : {1'b0, qt[DivStages][k]};
    dout.unit_x  = zero ? '0 : q[2];
    dout.unit_y  = zero ? '0 : q[1];
    dout.unit_z  = zero ? '0 : q[0];
    dout.length  = dv[DivStages];
    dout.is_zero = zero;
  end
  assign out_vld = vld[DivStages];
endmodule
